// ===== rtl/pph_pkg.sv =====
// shared codes and reset values for the parallel printer port host
// no dependencies

package pph_pkg;

    localparam int TimerWidth = 24;

    // operation codes of an input beat
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    // sequencer phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_POLL     = 3'd1;
    localparam logic [2:0] PH_SETUP    = 3'd2;
    localparam logic [2:0] PH_STROBE   = 3'd3;
    localparam logic [2:0] PH_HOLD     = 3'd4;
    localparam logic [2:0] PH_ACK      = 3'd5;
    localparam logic [2:0] PH_INIT_LOW = 3'd6;
    localparam logic [2:0] PH_INIT_REC = 3'd7;

    // completion status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OFFLINE = 3'd1;
    localparam logic [2:0] ST_PAPER   = 3'd2;
    localparam logic [2:0] ST_FAULT   = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_BUSY_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_SETUP        = 3'd1;
    localparam logic [2:0] CFG_STROBE       = 3'd2;
    localparam logic [2:0] CFG_HOLD         = 3'd3;
    localparam logic [2:0] CFG_ACK_CAP      = 3'd4;
    localparam logic [2:0] CFG_INIT_LOW     = 3'd5;
    localparam logic [2:0] CFG_INIT_RECOVER = 3'd6;
    localparam logic [2:0] CFG_IGNORE       = 3'd7;

    // configuration reset values
    localparam logic [23:0] RST_BUSY_TIMEOUT = 24'd1000000;
    localparam logic [7:0]  RST_SETUP        = 8'd2;
    localparam logic [7:0]  RST_STROBE       = 8'd2;
    localparam logic [7:0]  RST_HOLD         = 8'd2;
    localparam logic [15:0] RST_ACK_CAP      = 16'd2000;
    localparam logic [15:0] RST_INIT_LOW     = 16'd100;
    localparam logic [23:0] RST_INIT_RECOVER = 24'd50000;

endpackage

// ===== rtl/parallel_printer_port_host_unit.sv =====
// top level of the parallel printer port host: tick sequencer and output register
// depends on pph_pkg

// Each input beat is one timing tick (optionally carrying a write or init request)
// and yields exactly one result beat. The whole sequencer step - request intake,
// status poll, phase timer update and phase change - is done in one combinational
// pass between the state registers and the result register, so one beat is
// accepted every clock and its result appears in the next cycle. The result
// register lets the next beat enter while a result waits to be taken; input
// stalls only while that register is full and not being drained. There is no
// clearing pass after reset. Configuration writes take effect on the next clock.
module parallel_printer_port_host_unit
    import pph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic        busy_line,
    input  logic        select_line,
    input  logic        paper_end_line,
    input  logic        error_n_line,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_lines,
    output logic        strobe_n,
    output logic        init_n,
    output logic        idle,
    output logic        done_res,
    output logic [2:0]  result_status,
    output logic        rejected
);

    // configuration registers
    logic [23:0] busy_timeout_reg;
    logic [7:0]  setup_reg;
    logic [7:0]  strobe_reg;
    logic [7:0]  hold_reg;
    logic [15:0] ack_cap_reg;
    logic [15:0] init_low_reg;
    logic [23:0] init_recover_reg;
    logic        ignore_reg;

    // sequencer state
    logic [2:0]            phase_reg, phase_next;
    logic [TimerWidth-1:0] timer_reg, timer_next;
    logic [7:0]            data_hold_reg, data_hold_next;
    logic [7:0]            bus_reg, bus_next;
    logic [2:0]            status_reg, status_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] data_lines_reg;
    logic       strobe_n_reg;
    logic       init_n_reg;
    logic       idle_reg;
    logic       done_reg;
    logic [2:0] result_status_reg;
    logic       rejected_reg;

    logic                  in_accept;
    logic                  is_request;
    logic                  fresh_init;
    logic                  rej;
    logic                  done;
    logic [2:0]            cur_phase;
    logic [TimerWidth-1:0] cur_timer;
    logic [TimerWidth-1:0] dec_timer;
    logic [TimerWidth-1:0] strobe_len;
    logic [TimerWidth-1:0] init_low_len;
    logic                  poll_end;
    logic [2:0]            poll_code;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // zero widths count as one tick
    assign strobe_len   = (strobe_reg == 8'd0) ? TimerWidth'(1)
                                               : TimerWidth'(strobe_reg);
    assign init_low_len = (init_low_reg == 16'd0) ? TimerWidth'(1)
                                                  : TimerWidth'(init_low_reg);

    assign is_request = (operation == OP_WRITE) || (operation == OP_INIT);

    // status poll, checked in priority order
    always_comb
    begin
        poll_end  = 1'b1;
        poll_code = ST_OK;
        if (!ignore_reg && !select_line)
        begin
            poll_code = ST_OFFLINE;
        end
        else if (!ignore_reg && paper_end_line)
        begin
            poll_code = ST_PAPER;
        end
        else if (!ignore_reg && !error_n_line)
        begin
            poll_code = ST_FAULT;
        end
        else if (!busy_line)
        begin
            poll_code = ST_OK;
        end
        else if (cur_timer >= busy_timeout_reg)
        begin
            poll_code = ST_TIMEOUT;
        end
        else
        begin
            poll_end = 1'b0;
        end
    end

    // request intake from idle; a request arriving outside idle is flagged as rejected
    always_comb
    begin
        cur_phase      = phase_reg;
        cur_timer      = timer_reg;
        data_hold_next = data_hold_reg;
        fresh_init     = 1'b0;
        rej            = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (operation == OP_WRITE)
            begin
                data_hold_next = data_byte;
                cur_phase      = PH_POLL;
                cur_timer      = '0;
            end
            else if (operation == OP_INIT)
            begin
                cur_phase  = PH_INIT_LOW;
                cur_timer  = init_low_len;
                fresh_init = 1'b1;
            end
        end
        else if (is_request)
        begin
            rej = 1'b1;
        end
    end

    assign dec_timer = (cur_timer != '0) ? cur_timer - TimerWidth'(1) : cur_timer;

    // one sequencer step on the phase left by intake
    always_comb
    begin
        phase_next  = cur_phase;
        timer_next  = cur_timer;
        bus_next    = bus_reg;
        status_next = status_reg;
        done        = 1'b0;
        unique case (cur_phase)
            PH_IDLE:
            begin
            end
            PH_POLL:
            begin
                if (poll_end && poll_code == ST_OK)
                begin
                    bus_next = data_hold_next;
                    if (setup_reg == 8'd0)
                    begin
                        phase_next = PH_STROBE;
                        timer_next = strobe_len;
                    end
                    else
                    begin
                        phase_next = PH_SETUP;
                        timer_next = TimerWidth'(setup_reg);
                    end
                end
                else if (poll_end)
                begin
                    status_next = poll_code;
                    done        = 1'b1;
                    phase_next  = PH_IDLE;
                    timer_next  = '0;
                end
                else
                begin
                    timer_next = cur_timer + TimerWidth'(1);
                end
            end
            PH_ACK:
            begin
                if (busy_line || cur_timer > TimerWidth'(ack_cap_reg))
                begin
                    status_next = ST_OK;
                    done        = 1'b1;
                    phase_next  = PH_IDLE;
                    timer_next  = '0;
                end
                else
                begin
                    timer_next = cur_timer + TimerWidth'(1);
                end
            end
            PH_SETUP, PH_STROBE, PH_HOLD, PH_INIT_LOW, PH_INIT_REC:
            begin
                // an init pulse entered on this tick starts counting on the next
                if (!fresh_init)
                begin
                    timer_next = dec_timer;
                    if (dec_timer == '0)
                    begin
                        unique case (cur_phase)
                            PH_SETUP:
                            begin
                                phase_next = PH_STROBE;
                                timer_next = strobe_len;
                            end
                            PH_STROBE:
                            begin
                                if (hold_reg == 8'd0)
                                begin
                                    phase_next = PH_ACK;
                                    timer_next = '0;
                                end
                                else
                                begin
                                    phase_next = PH_HOLD;
                                    timer_next = TimerWidth'(hold_reg);
                                end
                            end
                            PH_HOLD:
                            begin
                                phase_next = PH_ACK;
                                timer_next = '0;
                            end
                            PH_INIT_LOW:
                            begin
                                if (init_recover_reg == 24'd0)
                                begin
                                    phase_next = PH_IDLE;
                                    timer_next = '0;
                                end
                                else
                                begin
                                    phase_next = PH_INIT_REC;
                                    timer_next = TimerWidth'(init_recover_reg);
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                timer_next = '0;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_timeout_reg <= RST_BUSY_TIMEOUT;
            setup_reg        <= RST_SETUP;
            strobe_reg       <= RST_STROBE;
            hold_reg         <= RST_HOLD;
            ack_cap_reg      <= RST_ACK_CAP;
            init_low_reg     <= RST_INIT_LOW;
            init_recover_reg <= RST_INIT_RECOVER;
            ignore_reg       <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_BUSY_TIMEOUT: busy_timeout_reg <= cfg_data;
                CFG_SETUP:        setup_reg        <= cfg_data[7:0];
                CFG_STROBE:       strobe_reg       <= cfg_data[7:0];
                CFG_HOLD:         hold_reg         <= cfg_data[7:0];
                CFG_ACK_CAP:      ack_cap_reg      <= cfg_data[15:0];
                CFG_INIT_LOW:     init_low_reg     <= cfg_data[15:0];
                CFG_INIT_RECOVER: init_recover_reg <= cfg_data;
                CFG_IGNORE:       ignore_reg       <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            data_hold_reg <= '0;
            bus_reg       <= '0;
            status_reg    <= ST_OK;
        end
        else if (in_accept)
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            data_hold_reg <= data_hold_next;
            bus_reg       <= bus_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_lines_reg    <= bus_next;
            strobe_n_reg      <= (phase_next != PH_STROBE);
            init_n_reg        <= (phase_next != PH_INIT_LOW);
            idle_reg          <= (phase_next == PH_IDLE);
            done_reg          <= done;
            result_status_reg <= status_next;
            rejected_reg      <= rej;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_lines    = data_lines_reg;
    assign strobe_n      = strobe_n_reg;
    assign init_n        = init_n_reg;
    assign idle          = idle_reg;
    assign done_res      = done_reg;
    assign result_status = result_status_reg;
    assign rejected      = rejected_reg;

endmodule

// ===== rtl/pph_checker.sv =====
// port-level checks for the parallel printer port host, bound to the top level
// depends on pph_pkg and parallel_printer_port_host_unit

module pph_checker
    import pph_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  data_lines,
    input logic        strobe_n,
    input logic        init_n,
    input logic        idle,
    input logic        done_res,
    input logic [2:0]  result_status,
    input logic        rejected
);

    // a stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_lines) && $stable(strobe_n)
            && $stable(init_n) && $stable(idle) && $stable(done_res)
            && $stable(result_status) && $stable(rejected))
        else $error("result beat changed while stalled");

    // a full, stalled result register blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result register full");

    // strobe and init pulses only run inside a sequence, never together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!strobe_n || !init_n) |-> !idle && (strobe_n || init_n))
        else $error("strobe or init pulse outside a sequence");

    // a finished write leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> idle)
        else $error("write completion without returning to idle");

    // status code stays within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_status <= ST_TIMEOUT)
        else $error("undefined result status");

endmodule

bind parallel_printer_port_host_unit pph_checker u_pph_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for parallel_printer_port_host_unit: tick beats in, port levels out
// depends on pph_pkg and the rtl top level; predicts every result beat and compares in order

module testbench;
    import pph_pkg::*;

    // operation code three carries no request
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       busy;
        logic       sel;
        logic       pe;
        logic       errn;
    } beat_t;

    typedef struct packed {
        logic [7:0] data_lines;
        logic       strobe_n;
        logic       init_n;
        logic       idle;
        logic       done;
        logic [2:0] status;
        logic       rejected;
    } levels_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [23:0] timer;
        logic [7:0]  held;
        logic [7:0]  bus;
        logic [2:0]  status;
    } port_state_t;

    typedef struct packed {
        logic [23:0] busy_timeout;
        logic [7:0]  setup;
        logic [7:0]  strobe;
        logic [7:0]  hold;
        logic [15:0] ack_cap;
        logic [15:0] init_low;
        logic [23:0] init_rec;
        logic        ignore;
    } port_cfg_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready;
    beat_t       cur_beat;
    levels_t     seen;

    port_cfg_t   port_cfg;
    port_state_t port_model;
    port_state_t plan_state;
    beat_t       beats_to_send[$];
    levels_t     expected_levels[$];

    logic        in_taken;
    bit          calm;
    int          send_gap;
    int          recv_gap;
    int          quiet_cycles;
    int          error_count;
    int          result_count;
    levels_t     predicted;
    levels_t     want;

    parallel_printer_port_host_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (cur_beat.op),
        .data_byte      (cur_beat.data),
        .busy_line      (cur_beat.busy),
        .select_line    (cur_beat.sel),
        .paper_end_line (cur_beat.pe),
        .error_n_line   (cur_beat.errn),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_lines     (seen.data_lines),
        .strobe_n       (seen.strobe_n),
        .init_n         (seen.init_n),
        .idle           (seen.idle),
        .done_res       (seen.done),
        .result_status  (seen.status),
        .rejected       (seen.rejected)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- sequencer prediction ----------------

    function automatic logic [2:0] next_after(input logic [2:0] p);
        case (p)
            PH_SETUP:    return PH_STROBE;
            PH_STROBE:   return PH_HOLD;
            PH_HOLD:     return PH_ACK;
            PH_INIT_LOW: return PH_INIT_REC;
            default:     return PH_IDLE;
        endcase
    endfunction

    // zero-length phases fall straight through to the next one
    function automatic port_state_t enter_phase(input port_state_t s, input logic [2:0] p);
        logic [2:0]  ph;
        logic [23:0] n;
        bit          settled;
        ph = p;
        n = '0;
        settled = 1'b0;
        while (!settled)
        begin
            settled = 1'b1;
            n = '0;
            case (ph)
                PH_SETUP:
                begin
                    n = 24'(port_cfg.setup);
                    if (n == 0)
                    begin
                        ph = PH_STROBE;
                        settled = 1'b0;
                    end
                end
                PH_STROBE:   n = (port_cfg.strobe == 0) ? 24'd1 : 24'(port_cfg.strobe);
                PH_HOLD:
                begin
                    n = 24'(port_cfg.hold);
                    if (n == 0)
                    begin
                        ph = PH_ACK;
                        settled = 1'b0;
                    end
                end
                PH_INIT_LOW: n = (port_cfg.init_low == 0) ? 24'd1 : 24'(port_cfg.init_low);
                PH_INIT_REC:
                begin
                    n = port_cfg.init_rec;
                    if (n == 0)
                    begin
                        ph = PH_IDLE;
                        settled = 1'b0;
                    end
                end
                default:     n = '0;
            endcase
        end
        s.phase = ph;
        s.timer = n;
        return s;
    endfunction

    function automatic levels_t advance_port(inout port_state_t s, input beat_t b);
        bit         req;
        bit         was_idle;
        bit         rej;
        bit         done;
        bit         ended;
        logic [2:0] code;
        levels_t    r;
        req = (b.op == OP_WRITE) || (b.op == OP_INIT);
        was_idle = (s.phase == PH_IDLE);
        rej = 1'b0;
        done = 1'b0;
        ended = 1'b0;
        code = ST_OK;

        if (was_idle)
        begin
            if (b.op == OP_WRITE)
            begin
                s.held = b.data;
                s.phase = PH_POLL;
                s.timer = '0;
            end
            else if (b.op == OP_INIT)
                s = enter_phase(s, PH_INIT_LOW);
        end
        else if (req)
            rej = 1'b1;

        case (s.phase)
            PH_POLL:
            begin
                if (!port_cfg.ignore && !b.sel)
                begin
                    ended = 1'b1;
                    code = ST_OFFLINE;
                end
                else if (!port_cfg.ignore && b.pe)
                begin
                    ended = 1'b1;
                    code = ST_PAPER;
                end
                else if (!port_cfg.ignore && !b.errn)
                begin
                    ended = 1'b1;
                    code = ST_FAULT;
                end
                else if (!b.busy)
                    ended = 1'b1;
                else if (s.timer >= port_cfg.busy_timeout)
                begin
                    ended = 1'b1;
                    code = ST_TIMEOUT;
                end
                else
                    s.timer = s.timer + 24'd1;
                if (ended)
                begin
                    if (code == ST_OK)
                    begin
                        s.bus = s.held;
                        s = enter_phase(s, PH_SETUP);
                    end
                    else
                    begin
                        s.status = code;
                        done = 1'b1;
                        s.phase = PH_IDLE;
                        s.timer = '0;
                    end
                end
            end
            PH_ACK:
            begin
                if (b.busy || s.timer > port_cfg.ack_cap)
                begin
                    s.status = ST_OK;
                    done = 1'b1;
                    s.phase = PH_IDLE;
                    s.timer = '0;
                end
                else
                    s.timer = s.timer + 24'd1;
            end
            PH_SETUP, PH_STROBE, PH_HOLD, PH_INIT_LOW, PH_INIT_REC:
            begin
                // a phase entered by this very beat does not count down yet
                if (!(was_idle && req))
                begin
                    if (s.timer > 0)
                        s.timer = s.timer - 24'd1;
                    if (s.timer == 0)
                        s = enter_phase(s, next_after(s.phase));
                end
            end
            default: ;
        endcase

        r.data_lines = s.bus;
        r.strobe_n = (s.phase != PH_STROBE);
        r.init_n = (s.phase != PH_INIT_LOW);
        r.idle = (s.phase == PH_IDLE);
        r.done = done;
        r.status = s.status;
        r.rejected = rej;
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic flag_error(input string msg);
        $display("error at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input int got, input int exp_val);
        if (got != exp_val)
            flag_error($sformatf("beat %0d %s got %0d expected %0d",
                                 result_count, field, got, exp_val));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predicted = advance_port(port_model, cur_beat);
                expected_levels.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                    flag_error($sformatf("beat %0d arrived with nothing expected", result_count));
                else
                begin
                    want = expected_levels.pop_front();
                    check_field("data_lines", int'(seen.data_lines), int'(want.data_lines));
                    check_field("strobe_n", int'(seen.strobe_n), int'(want.strobe_n));
                    check_field("init_n", int'(seen.init_n), int'(want.init_n));
                    check_field("idle", int'(seen.idle), int'(want.idle));
                    check_field("done_res", int'(seen.done), int'(want.done));
                    check_field("result_status", int'(seen.status), int'(want.status));
                    check_field("rejected", int'(seen.rejected), int'(want.rejected));
                end
                result_count++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    // ---------------- driving ----------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 12);
                    in_valid <= 1'b0;
                end
                else if (beats_to_send.size() > 0)
                begin
                    cur_beat <= beats_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_beat(input beat_t b);
        void'(advance_port(plan_state, b));
        beats_to_send.push_back(b);
    endtask

    task automatic send(input logic [1:0] op, input logic [7:0] data, input logic busy,
                        input logic sel, input logic pe, input logic errn);
        beat_t b;
        b.op = op;
        b.data = data;
        b.busy = busy;
        b.sel = sel;
        b.pe = pe;
        b.errn = errn;
        queue_beat(b);
    endtask

    task automatic send_until_idle(input logic busy);
        while (plan_state.phase != PH_IDLE)
            send(OP_TICK, 8'($urandom_range(0, 255)), busy, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        while (beats_to_send.size() != 0 || in_valid || expected_levels.size() != 0)
            @(negedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic load_config(input port_cfg_t c);
        put_reg(CFG_BUSY_TIMEOUT, c.busy_timeout);
        put_reg(CFG_SETUP, 24'(c.setup));
        put_reg(CFG_STROBE, 24'(c.strobe));
        put_reg(CFG_HOLD, 24'(c.hold));
        put_reg(CFG_ACK_CAP, 24'(c.ack_cap));
        put_reg(CFG_INIT_LOW, 24'(c.init_low));
        put_reg(CFG_INIT_RECOVER, c.init_rec);
        put_reg(CFG_IGNORE, 24'(c.ignore));
        @(negedge clk);
        cfg_write_en <= 1'b0;
        port_cfg = c;
    endtask

    function automatic port_cfg_t pick_short_cfg(input bit ignore);
        port_cfg_t c;
        c.busy_timeout = 24'($urandom_range(0, 12));
        c.setup = 8'($urandom_range(0, 4));
        c.strobe = 8'($urandom_range(0, 4));
        c.hold = 8'($urandom_range(0, 4));
        c.ack_cap = 16'($urandom_range(0, 10));
        c.init_low = 16'($urandom_range(0, 6));
        c.init_rec = 24'($urandom_range(0, 8));
        c.ignore = ignore;
        return c;
    endfunction

    // mostly healthy status lines so writes get past the poll
    function automatic beat_t pick_lines(input logic [2:0] ph);
        beat_t b;
        b.op = OP_TICK;
        b.data = 8'($urandom_range(0, 255));
        if (ph == PH_POLL || ph == PH_IDLE)
            b.busy = ($urandom_range(0, 99) < 60);
        else if (ph == PH_ACK)
            b.busy = ($urandom_range(0, 99) < 30);
        else
            b.busy = 1'($urandom_range(0, 1));
        b.sel = ($urandom_range(0, 99) >= 7);
        b.pe = ($urandom_range(0, 99) < 6);
        b.errn = ($urandom_range(0, 99) >= 6);
        return b;
    endfunction

    task automatic run_random(input int budget, input bit allow_init);
        int    count;
        int    pick;
        beat_t b;
        count = 0;
        while (count < budget || plan_state.phase != PH_IDLE)
        begin
            b = pick_lines(plan_state.phase);
            pick = $urandom_range(0, 99);
            if (plan_state.phase == PH_IDLE)
            begin
                if (pick < 55)
                    b.op = OP_WRITE;
                else if (pick < 70 && allow_init)
                    b.op = OP_INIT;
                else if (pick < 76)
                    b.op = OP_SPARE;
            end
            else
            begin
                // stray requests in the middle of a sequence
                if (pick < 3)
                    b.op = OP_WRITE;
                else if (pick < 6 && allow_init)
                    b.op = OP_INIT;
                else if (pick < 8)
                    b.op = OP_SPARE;
            end
            queue_beat(b);
            count++;
        end
    endtask

    initial
    begin
        port_cfg_t c;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_BUSY_TIMEOUT;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cur_beat = '0;
        in_taken = 1'b0;
        calm = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        quiet_cycles = 0;
        error_count = 0;
        result_count = 0;
        port_cfg.busy_timeout = RST_BUSY_TIMEOUT;
        port_cfg.setup = RST_SETUP;
        port_cfg.strobe = RST_STROBE;
        port_cfg.hold = RST_HOLD;
        port_cfg.ack_cap = RST_ACK_CAP;
        port_cfg.init_low = RST_INIT_LOW;
        port_cfg.init_rec = RST_INIT_RECOVER;
        port_cfg.ignore = 1'b0;
        port_model = '0;
        plan_state = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // full write at the reset timing, busy stays low into the ack phase
        send(OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b1);
        repeat (7) send(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
        send_until_idle(1'b1);
        wait_drained();

        // zero strobe and init widths, busy timeout of one tick
        c.busy_timeout = 24'd1;
        c.setup = 8'd0;
        c.strobe = 8'd0;
        c.hold = 8'd0;
        c.ack_cap = 16'd1;
        c.init_low = 16'd0;
        c.init_rec = 24'd1;
        c.ignore = 1'b0;
        load_config(c);
        send(OP_WRITE, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b1);
        send(OP_WRITE, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b1);
        send(OP_WRITE, 8'h3C, 1'b0, 1'b1, 1'b0, 1'b0);
        send(OP_WRITE, 8'hC3, 1'b1, 1'b1, 1'b0, 1'b1);
        send(OP_TICK, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1);
        send(OP_SPARE, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0);
        send(OP_INIT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
        send(OP_WRITE, 8'h11, 1'b0, 1'b1, 1'b0, 1'b1);
        send(OP_INIT, 8'h22, 1'b0, 1'b1, 1'b0, 1'b1);
        send_until_idle(1'b0);
        send(OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
        send_until_idle(1'b0);
        wait_drained();

        load_config(pick_short_cfg(1'b0));
        run_random(90, 1'b1);
        wait_drained();

        // every register at its low end, status checks off
        c = '0;
        c.ignore = 1'b1;
        load_config(c);
        run_random(70, 1'b1);
        wait_drained();

        // sender holds off halfway until the port has caught up
        load_config(pick_short_cfg(1'b1));
        run_random(40, 1'b1);
        wait_drained();
        run_random(40, 1'b1);
        wait_drained();

        // every timing register at its high end, status checks on; no init, its recovery would take too long
        c.busy_timeout = 24'hFFFFFF;
        c.setup = 8'hFF;
        c.strobe = 8'hFF;
        c.hold = 8'hFF;
        c.ack_cap = 16'hFFFF;
        c.init_low = 16'hFFFF;
        c.init_rec = 24'hFFFFFF;
        c.ignore = 1'b0;
        load_config(c);
        run_random(300, 1'b0);
        wait_drained();

        load_config(pick_short_cfg(1'($urandom_range(0, 1))));
        calm = 1'b1;
        run_random(70, 1'b1);
        wait_drained();
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pph_pkg.sv
rtl/parallel_printer_port_host_unit.sv
rtl/pph_checker.sv
dv/testbench.sv
